@@ rtl/tsts_pkg.sv @@
// Shared types and constants of the time-slice task scheduler.
// Used by tsts_ctrl, tsts_dp and time_slice_task_scheduler; no dependencies.
package tsts_pkg;

  // Widths of the word fields.
  localparam int unsigned ID_W    = 4;
  localparam int unsigned NS_W    = 2;
  localparam int unsigned SLICE_W = 16;
  localparam int unsigned CNT_W   = 32;

  // Packed widths of the stream data buses, filled up to whole bytes.
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 88;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  typedef enum logic [1:0] {
    TS_UNUSED  = 2'd0,
    TS_READY   = 2'd1,
    TS_BLOCKED = 2'd2,
    TS_RUNNING = 2'd3
  } task_state_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_RETIRE,
    CS_SCAN,
    CS_PICK,
    CS_COUNT,
    CS_REPLY
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic retire;
    logic scan;
    logic pick;
    logic count;
    logic reply;
  } dp_cmd_t;

  typedef struct packed {
    logic req_set;
    logic need_disp;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/time_slice_task_scheduler.sv @@
// Top level of the round-robin time-slice task scheduler.
// Depends on tsts_pkg and instantiates tsts_ctrl and tsts_dp.
//
// Usage: each word on the slave stream is a request. The tuser bit gives its
// kind: a timer tick, or a request that sets the state of one task (task_id
// and new_state in tdata). Every request yields exactly one word on the master
// stream with the switch flag in tuser and the running task, remaining slice,
// tick total and running task's dispatch count in tdata.
// The slice length register is written through the cfg channel, which is
// always ready; it should be written only while no request is in flight.
// Flow: a state request or a tick that does not dispatch goes from decode
// straight to reply. A dispatching tick then scans the task state memory one
// entry per cycle through its single read port, so the time to its result
// depends on where the next ready task sits in round-robin order. One request
// is handled at a time; the next word is accepted as soon as the previous
// result is registered.
// When the receiver stalls, the result waits in the output register and the
// next request is still taken and processed up to its own reply.
// Reset: task 0 runs with a slice of ten ticks, all other tasks are unused,
// counters are zero and the slice length is ten.
module time_slice_task_scheduler #(
  parameter int unsigned TASKS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slice length register write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsts_pkg::SLICE_W-1:0]   cfg_data_i,
  // Request stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: task_id [3:0], new_state [5:4], zero [7:6]
  input  logic [tsts_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: req_type
  input  logic                           s_axis_tuser_i,
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: running_task [3:0], slice_left [19:4], tick_total [51:20],
  //        running_dispatches [83:52], zero [87:84]
  output logic [tsts_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: switched
  output logic                           m_axis_tuser_o
);
  import tsts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tsts_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  tsts_dp #(
    .TASKS (TASKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

`ifndef SYNTH
  // Only one request is in flight: an accepted word closes the input at once.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second word accepted while a request is in flight");

  // A state request never reports a dispatch.
  a_set_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.reply && status.req_set |=> !m_axis_tuser_o)
    else $error("state request reported a dispatch");

  // A reply always lands in the output register.
  a_reply_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.reply |=> m_axis_tvalid_o)
    else $error("reply not presented on the result stream");
`endif

endmodule

@@ rtl/tsts_ctrl.sv @@
// Sequencing state machine of the task scheduler.
// Depends on tsts_pkg; drives the commands of tsts_dp from its status.
module tsts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  tsts_pkg::dp_status_t status_i,
  output tsts_pkg::dp_cmd_t    cmd_o
);
  import tsts_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (s_axis_tvalid_i) state_d = CS_DECODE;
      end
      CS_DECODE: begin
        if (!status_i.req_set && status_i.need_disp) state_d = CS_RETIRE;
        else state_d = CS_REPLY;
      end
      CS_RETIRE: state_d = CS_SCAN;
      CS_SCAN: begin
        if (status_i.scan_done) state_d = CS_PICK;
      end
      CS_PICK:  state_d = CS_COUNT;
      CS_COUNT: state_d = CS_REPLY;
      CS_REPLY: begin
        if (status_i.out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == CS_IDLE);
    cmd_o        = '0;
    cmd_o.load   = (state_q == CS_IDLE) && s_axis_tvalid_i;
    cmd_o.decode = (state_q == CS_DECODE);
    cmd_o.retire = (state_q == CS_RETIRE);
    cmd_o.scan   = (state_q == CS_SCAN);
    cmd_o.pick   = (state_q == CS_PICK);
    cmd_o.count  = (state_q == CS_COUNT);
    cmd_o.reply  = (state_q == CS_REPLY) && status_i.out_free;
  end

endmodule

@@ rtl/tsts_dp.sv @@
// Datapath of the task scheduler: task state memory, dispatch count memory,
// counters, round-robin scan and output register. Depends on tsts_pkg.
module tsts_dp #(
  parameter int unsigned TASKS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tsts_pkg::dp_cmd_t                 cmd_i,
  output tsts_pkg::dp_status_t              status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsts_pkg::SLICE_W-1:0]      cfg_data_i,
  input  logic [tsts_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [tsts_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tuser_o
);
  import tsts_pkg::*;

  localparam int unsigned TW = $clog2(TASKS);
  localparam int unsigned IW = ((TW > ID_W) ? TW : ID_W) + 1;
  localparam int unsigned CW = TW + 1;

  // Request register.
  logic              req_q;
  logic [ID_W-1:0]   id_q;
  logic [NS_W-1:0]   ns_q;

  // Scheduler state.
  logic [SLICE_W-1:0] slice_len_q;
  logic [TW-1:0]      cur_q;
  logic               cur_run_q;
  logic [SLICE_W-1:0] slice_q;
  logic [CNT_W-1:0]   tick_q;
  logic [CNT_W-1:0]   cur_disp_q;
  logic               sw_q;

  // Task state memory with per-entry valid bits.
  logic [NS_W-1:0]    state_mem [TASKS];
  logic [TASKS-1:0]   state_vld_q;
  logic [NS_W-1:0]    st_rd_q;
  logic               st_rd_vld_q;
  logic               st_we;
  logic [TW-1:0]      st_waddr;
  logic [NS_W-1:0]    st_wdata;
  logic [NS_W-1:0]    st_eff;

  // Scan pipeline: read issue, then check in the next cycle.
  logic [TW-1:0]      scan_ptr_q;
  logic [CW-1:0]      scan_cnt_q;
  logic               chk_vld_q;
  logic [TW-1:0]      chk_addr_q;
  logic [TW-1:0]      next_q;
  logic               issue;
  logic               found;

  // Dispatch count memory with per-entry valid bits.
  logic [CNT_W-1:0]   disp_mem [TASKS];
  logic [TASKS-1:0]   disp_vld_q;
  logic [CNT_W-1:0]   disp_rd_q;
  logic               disp_rd_vld_q;
  logic [CNT_W-1:0]   dcount;

  // Output register.
  logic               out_vld_q;
  logic               out_sw_q;
  logic [ID_W-1:0]    out_task_q;
  logic [SLICE_W-1:0] out_slice_q;
  logic [CNT_W-1:0]   out_tick_q;
  logic [CNT_W-1:0]   out_disp_q;

  logic               id_legal;
  logic [TW-1:0]      id_idx;
  logic               set_ok;
  logic [SLICE_W-1:0] slice_dec;
  logic               need_disp;
  logic               out_free;
  logic [TW-1:0]      ptr_first;

  assign id_legal  = IW'(id_q) < IW'(TASKS);
  assign id_idx    = TW'(id_q);
  assign set_ok    = id_legal && (ns_q != TS_RUNNING);
  assign slice_dec = (slice_q != '0) ? slice_q - 1'b1 : '0;
  assign need_disp = (slice_dec == '0) || !cur_run_q;
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign ptr_first = (cur_q == TW'(TASKS - 1)) ? '0 : cur_q + 1'b1;

  // A never-written entry holds its reset value: task 0 running, others unused.
  assign st_eff = st_rd_vld_q ? st_rd_q : ((chk_addr_q == '0) ? TS_RUNNING : TS_UNUSED);
  assign issue  = cmd_i.scan && (scan_cnt_q != CW'(TASKS));
  assign found  = chk_vld_q && (chk_addr_q != '0) && (st_eff == TS_READY);
  assign dcount = (disp_rd_vld_q ? disp_rd_q : '0) + 1'b1;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = cur_q;
    st_wdata = TS_READY;
    if (cmd_i.decode && (req_q == REQ_SET) && set_ok) begin
      st_we    = 1'b1;
      st_waddr = id_idx;
      st_wdata = ns_q;
    end else if (cmd_i.retire && cur_run_q) begin
      st_we    = 1'b1;
      st_waddr = cur_q;
      st_wdata = TS_READY;
    end else if (cmd_i.pick) begin
      st_we    = 1'b1;
      st_waddr = next_q;
      st_wdata = TS_RUNNING;
    end
  end

  assign status_o.req_set   = (req_q == REQ_SET);
  assign status_o.need_disp = need_disp;
  assign status_o.scan_done = found || ((scan_cnt_q == CW'(TASKS)) && !chk_vld_q);
  assign status_o.out_free  = out_free;

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_sw_q;
  assign m_axis_tdata_o  = {4'd0, out_disp_q, out_tick_q, out_slice_q, out_task_q};

  always_ff @(posedge clk_i) begin
    if (st_we) state_mem[st_waddr] <= st_wdata;
    if (issue) st_rd_q <= state_mem[scan_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.count) disp_mem[cur_q] <= dcount;
    if (cmd_i.pick) disp_rd_q <= disp_mem[next_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= s_axis_tuser_i;
      id_q  <= s_axis_tdata_i[ID_W-1:0];
      ns_q  <= s_axis_tdata_i[ID_W+NS_W-1:ID_W];
    end
    if (cmd_i.reply) begin
      out_sw_q    <= sw_q;
      out_task_q  <= ID_W'(cur_q);
      out_slice_q <= slice_q;
      out_tick_q  <= tick_q;
      out_disp_q  <= cur_disp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q   <= SLICE_RESET;
      cur_q         <= '0;
      cur_run_q     <= 1'b1;
      slice_q       <= SLICE_RESET;
      tick_q        <= '0;
      cur_disp_q    <= '0;
      sw_q          <= 1'b0;
      state_vld_q   <= '0;
      st_rd_vld_q   <= 1'b0;
      scan_ptr_q    <= '0;
      scan_cnt_q    <= '0;
      chk_vld_q     <= 1'b0;
      chk_addr_q    <= '0;
      next_q        <= '0;
      disp_vld_q    <= '0;
      disp_rd_vld_q <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) slice_len_q <= cfg_data_i;
      if (st_we) state_vld_q[st_waddr] <= 1'b1;

      if (cmd_i.decode) begin
        if (req_q == REQ_SET) begin
          sw_q <= 1'b0;
          if (set_ok && (id_idx == cur_q)) cur_run_q <= 1'b0;
        end else begin
          tick_q  <= tick_q + 1'b1;
          slice_q <= slice_dec;
          sw_q    <= need_disp;
        end
      end

      if (cmd_i.retire) begin
        scan_ptr_q <= ptr_first;
        scan_cnt_q <= '0;
        chk_vld_q  <= 1'b0;
        next_q     <= '0;
      end

      if (cmd_i.scan) begin
        chk_vld_q <= issue;
        if (issue) begin
          st_rd_vld_q <= state_vld_q[scan_ptr_q];
          chk_addr_q  <= scan_ptr_q;
          scan_ptr_q  <= (scan_ptr_q == TW'(TASKS - 1)) ? '0 : scan_ptr_q + 1'b1;
          scan_cnt_q  <= scan_cnt_q + 1'b1;
        end
        if (found) next_q <= chk_addr_q;
      end

      if (cmd_i.pick) begin
        cur_q         <= next_q;
        cur_run_q     <= 1'b1;
        slice_q       <= slice_len_q;
        disp_rd_vld_q <= disp_vld_q[next_q];
      end

      if (cmd_i.count) begin
        disp_vld_q[cur_q] <= 1'b1;
        cur_disp_q        <= dcount;
      end

      if (cmd_i.reply) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

endmodule
